>>> rtl/pclip_pkg.sv
// ----------------------------------------------------------------------------
// Polygon clipper package
// Sizes, vertex type and a coordinate helper used by the clipper unit.
// ----------------------------------------------------------------------------
package pclip_pkg;

  localparam int MAX_VERTS      = 16;
  localparam int MAX_CLIP_EDGES = 8;
  localparam int COORD_W        = 32;

  localparam int VI_W   = $clog2(MAX_VERTS);
  localparam int VC_W   = $clog2(MAX_VERTS + 1);
  localparam int EI_W   = $clog2(MAX_CLIP_EDGES);
  localparam int EC_W   = $clog2(MAX_CLIP_EDGES + 1);
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SIDE_W = PROD_W + 1;
  localparam int DEN_W  = SIDE_W + 1;
  localparam int MAG_W  = SIDE_W;
  localparam int REM_W  = MAG_W + 2;
  localparam int CNT_W  = $clog2(COORD_W);
  localparam int LANES  = 3;

  // Function codes of an input word.
  localparam logic FUNC_SUBJECT = 1'b0;
  localparam logic FUNC_WINDOW  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vert_t;

  localparam int VERT_W = $bits(vert_t);
  localparam int WIN_W  = 2 * COORD_W;

  // Coordinate of a vertex by lane number: 0 is x, 1 is y, 2 is z.
  function automatic logic signed [COORD_W-1:0] vcoord(vert_t v, logic [1:0] lane);
    logic signed [COORD_W-1:0] c;
    case (lane)
      2'd0:    c = v.x;
      2'd1:    c = v.y;
      default: c = v.z;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/polygon_clip_sutherland_hodgman_unit.sv
// ----------------------------------------------------------------------------
// Sutherland-Hodgman polygon clipper
// Clips a loaded subject polygon against a convex window in Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+------------------
//  input     | in_func in_pos_x/y/z in_final_vertex          | start & !busy
//  result    | out_x/y/z out_end_of_run out_empty_result ... | out_valid strobe
//
// A vertex is loaded in the idle state; busy stays low between loads.
// The window vertex with the final mark starts a run: per window edge a setup in W0,
// W1, W2 and a pass over the closing vertex, then VA, VM, VB, VC, EMITV per working
// vertex; per crossing DSET, a radix-2 multiply-divide loop over the 32 bits of the
// coordinate difference and EMITI. Results follow one per cycle, then busy drops.
// Reset clears all counters. The receiver cannot stall; each result shows one cycle.
module polygon_clip_sutherland_hodgman_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_func,
  input  logic signed [pclip_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [pclip_pkg::COORD_W-1:0]   in_pos_y,
  input  logic signed [pclip_pkg::COORD_W-1:0]   in_pos_z,
  input  logic                                   in_final_vertex,
  output logic                                   out_valid,
  output logic signed [pclip_pkg::COORD_W-1:0]   out_x,
  output logic signed [pclip_pkg::COORD_W-1:0]   out_y,
  output logic signed [pclip_pkg::COORD_W-1:0]   out_z,
  output logic                                   out_end_of_run,
  output logic                                   out_empty_result,
  output logic                                   out_overflowed
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_W0    = 4'd2;
  localparam logic [3:0] ST_W1    = 4'd3;
  localparam logic [3:0] ST_W2    = 4'd4;
  localparam logic [3:0] ST_VA    = 4'd5;
  localparam logic [3:0] ST_VM    = 4'd6;
  localparam logic [3:0] ST_VB    = 4'd7;
  localparam logic [3:0] ST_VC    = 4'd8;
  localparam logic [3:0] ST_DSET  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_EMITI = 4'd11;
  localparam logic [3:0] ST_EMITV = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;
  localparam logic [3:0] ST_OST   = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  localparam int CW = pclip_pkg::COORD_W;
  localparam int LN = pclip_pkg::LANES;

  // control
  logic [3:0]                   state_r, state_nxt;
  logic [pclip_pkg::VC_W-1:0]   scount_r, scount_nxt;
  logic [pclip_pkg::EC_W-1:0]   wcount_r, wcount_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         cur_r, cur_nxt;
  logic [pclip_pkg::VC_W-1:0]   n_r, n_nxt;
  logic [pclip_pkg::VC_W-1:0]   m_r, m_nxt;
  logic [pclip_pkg::VC_W-1:0]   j_r, j_nxt;
  logic [pclip_pkg::EC_W-1:0]   k_r, k_nxt;
  logic                         first_r, first_nxt;
  logic [pclip_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // datapath
  logic signed [CW-1:0]                    wsx_r, wsx_nxt, wsy_r, wsy_nxt;
  logic signed [pclip_pkg::DIFF_W-1:0]     ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [pclip_pkg::DIFF_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  pclip_pkg::vert_t                        cand_r, cand_nxt, prev_r, prev_nxt;
  logic signed [pclip_pkg::PROD_W-1:0]     p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [pclip_pkg::SIDE_W-1:0]     fp_r, fp_nxt, fs_r, fs_nxt;
  logic                                    ins_r, ins_nxt, inp_r, inp_nxt;
  logic signed [pclip_pkg::DEN_W-1:0]      den_r, den_nxt;
  logic [pclip_pkg::MAG_W-1:0]             num_r, num_nxt, dena_r, dena_nxt;
  logic [CW-1:0]                           ud_r [LN], ud_nxt [LN];
  logic [CW-1:0]                           q_r [LN], q_nxt [LN];
  logic [pclip_pkg::REM_W-1:0]             rem_r [LN], rem_nxt [LN];
  logic [LN-1:0]                           neg_r, neg_nxt;
  pclip_pkg::vert_t                        ovtx_r, ovtx_nxt;
  logic                                    oend_r, oend_nxt, oemp_r, oemp_nxt;
  logic                                    oovf_r, oovf_nxt;

  // memories
  logic                          vram_we;
  logic [pclip_pkg::VI_W:0]      vram_waddr, vram_raddr;
  pclip_pkg::vert_t              vram_wdata, vram_rdata;
  logic                          wram_we;
  logic [pclip_pkg::EI_W-1:0]    wram_waddr, wram_raddr;
  logic [pclip_pkg::WIN_W-1:0]   wram_wdata, wram_rdata;

  // The working lists live in two banks of one RAM: a stage reads the current
  // bank and writes the other, so a read and a write never meet on one entry.
  pclip_ram #(.WIDTH(pclip_pkg::VERT_W), .DEPTH(2 * pclip_pkg::MAX_VERTS)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  pclip_ram #(.WIDTH(pclip_pkg::WIN_W), .DEPTH(pclip_pkg::MAX_CLIP_EDGES)) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  always_comb begin
    logic                              vfull;
    logic                              inp_c;
    logic [pclip_pkg::EC_W-1:0]        kp1;
    logic [pclip_pkg::VC_W-1:0]        jp1;
    logic [pclip_pkg::VC_W-1:0]        m_after;
    logic signed [pclip_pkg::DIFF_W-1:0] ld;
    logic signed [pclip_pkg::DIFF_W-1:0] lr;
    logic signed [CW-1:0]              la;
    logic signed [CW-1:0]              lb;
    logic [pclip_pkg::REM_W-1:0]       t;
    logic [pclip_pkg::REM_W-1:0]       d1;
    logic [pclip_pkg::REM_W-1:0]       d2;
    logic [1:0]                        dig;
    logic signed [CW-1:0]              res [LN];

    state_nxt     = state_r;
    scount_nxt    = scount_r;
    wcount_nxt    = wcount_r;
    ovf_nxt       = ovf_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    wsx_nxt = wsx_r; wsy_nxt = wsy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    dx_nxt = dx_r; dy_nxt = dy_r; cand_nxt = cand_r; prev_nxt = prev_r;
    p1_nxt = p1_r; p2_nxt = p2_r; fp_nxt = fp_r; fs_nxt = fs_r;
    ins_nxt = ins_r; inp_nxt = inp_r; den_nxt = den_r;
    num_nxt = num_r; dena_nxt = dena_r; neg_nxt = neg_r;
    ud_nxt = ud_r; q_nxt = q_r; rem_nxt = rem_r;
    ovtx_nxt = ovtx_r; oend_nxt = oend_r; oemp_nxt = oemp_r; oovf_nxt = oovf_r;

    vfull      = (m_r == pclip_pkg::VC_W'(pclip_pkg::MAX_VERTS));
    inp_c      = fp_r[pclip_pkg::SIDE_W-1] || (fp_r == '0);
    kp1        = k_r + 1'b1;
    jp1        = j_r + 1'b1;
    m_after    = m_r;
    ld = '0; lr = '0; la = '0; lb = '0; t = '0; dig = '0;
    d1 = {2'b00, dena_r};
    d2 = {1'b0, dena_r, 1'b0};

    for (int i = 0; i < LN; i++) begin
      la = pclip_pkg::vcoord(prev_r, 2'(i));
      lr = neg_r[i] ? ($signed({la[CW-1], la}) - $signed({1'b0, q_r[i]}))
                    : ($signed({la[CW-1], la}) + $signed({1'b0, q_r[i]}));
      res[i] = lr[CW-1:0];
    end

    vram_we    = 1'b0;
    vram_waddr = {~cur_r, m_r[pclip_pkg::VI_W-1:0]};
    vram_wdata = cand_r;
    vram_raddr = {cur_r, j_r[pclip_pkg::VI_W-1:0]};
    wram_we    = 1'b0;
    wram_waddr = wcount_r[pclip_pkg::EI_W-1:0];
    wram_wdata = {in_pos_x, in_pos_y};
    wram_raddr = k_r[pclip_pkg::EI_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == pclip_pkg::FUNC_SUBJECT) begin
            if (scount_r < pclip_pkg::VC_W'(pclip_pkg::MAX_VERTS)) begin
              vram_we    = 1'b1;
              vram_waddr = {cur_r, scount_r[pclip_pkg::VI_W-1:0]};
              vram_wdata = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
              scount_nxt = scount_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (wcount_r < pclip_pkg::EC_W'(pclip_pkg::MAX_CLIP_EDGES)) begin
              wram_we    = 1'b1;
              wcount_nxt = wcount_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_final_vertex) begin
              state_nxt = ST_START;
            end
          end
        end
      end
      ST_START: begin
        n_nxt = scount_r;
        k_nxt = '0;
        m_nxt = '0;
        state_nxt = (scount_r == '0) ? ST_OUT : ST_W0;
      end
      ST_W0: begin
        state_nxt = ST_W1;
      end
      ST_W1: begin
        wsx_nxt    = wram_rdata[pclip_pkg::WIN_W-1:CW];
        wsy_nxt    = wram_rdata[CW-1:0];
        wram_raddr = (kp1 == wcount_r) ? '0 : kp1[pclip_pkg::EI_W-1:0];
        state_nxt  = ST_W2;
      end
      ST_W2: begin
        ex_nxt = $signed({wram_rdata[pclip_pkg::WIN_W-1], wram_rdata[pclip_pkg::WIN_W-1:CW]})
               - $signed({wsx_r[CW-1], wsx_r});
        ey_nxt = $signed({wram_rdata[CW-1], wram_rdata[CW-1:0]})
               - $signed({wsy_r[CW-1], wsy_r});
        jp1        = n_r - 1'b1;
        vram_raddr = {cur_r, jp1[pclip_pkg::VI_W-1:0]};
        first_nxt  = 1'b1;
        m_nxt      = '0;
        state_nxt  = ST_VA;
      end
      ST_VA: begin
        cand_nxt  = vram_rdata;
        dx_nxt    = $signed({vram_rdata.x[CW-1], vram_rdata.x}) - $signed({wsx_r[CW-1], wsx_r});
        dy_nxt    = $signed({vram_rdata.y[CW-1], vram_rdata.y}) - $signed({wsy_r[CW-1], wsy_r});
        state_nxt = ST_VM;
      end
      ST_VM: begin
        p1_nxt    = ey_r * dx_r;
        p2_nxt    = ex_r * dy_r;
        state_nxt = ST_VB;
      end
      ST_VB: begin
        fp_nxt    = p1_r - p2_r;
        state_nxt = ST_VC;
      end
      ST_VC: begin
        if (first_r) begin
          // The closing vertex of the list starts the walk as its predecessor.
          prev_nxt   = cand_r;
          fs_nxt     = fp_r;
          ins_nxt    = inp_c;
          first_nxt  = 1'b0;
          j_nxt      = '0;
          vram_raddr = {cur_r, {pclip_pkg::VI_W{1'b0}}};
          state_nxt  = ST_VA;
        end else begin
          inp_nxt   = inp_c;
          den_nxt   = fs_r - fp_r;
          state_nxt = (inp_c != ins_r) ? ST_DSET : ST_EMITV;
        end
      end
      ST_DSET: begin
        num_nxt  = pclip_pkg::MAG_W'(fs_r[pclip_pkg::SIDE_W-1] ? -fs_r : fs_r);
        dena_nxt = pclip_pkg::MAG_W'(den_r[pclip_pkg::DEN_W-1] ? -den_r : den_r);
        for (int i = 0; i < LN; i++) begin
          la = pclip_pkg::vcoord(prev_r, 2'(i));
          lb = pclip_pkg::vcoord(cand_r, 2'(i));
          ld = $signed({lb[CW-1], lb}) - $signed({la[CW-1], la});
          ud_nxt[i]  = CW'(ld[pclip_pkg::DIFF_W-1] ? -ld : ld);
          neg_nxt[i] = ld[pclip_pkg::DIFF_W-1] ^ fs_r[pclip_pkg::SIDE_W-1]
                     ^ den_r[pclip_pkg::DEN_W-1];
          rem_nxt[i] = '0;
          q_nxt[i]   = '0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // One bit of |d| a cycle: remainder stays below the denominator, so
        // each quotient digit is 0, 1 or 2.
        for (int i = 0; i < LN; i++) begin
          t = {rem_r[i][pclip_pkg::REM_W-2:0], 1'b0}
            + (ud_r[i][CW-1] ? {2'b00, num_r} : '0);
          if (t >= d2) begin
            t   = t - d2;
            dig = 2'd2;
          end else if (t >= d1) begin
            t   = t - d1;
            dig = 2'd1;
          end else begin
            dig = 2'd0;
          end
          rem_nxt[i] = t;
          q_nxt[i]   = {q_r[i][CW-2:0], 1'b0} + CW'(dig);
          ud_nxt[i]  = {ud_r[i][CW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pclip_pkg::CNT_W'(CW - 1)) begin
          state_nxt = ST_EMITI;
        end
      end
      ST_EMITI: begin
        if (vfull) begin
          ovf_nxt = 1'b1;
        end else begin
          vram_we    = 1'b1;
          vram_wdata = '{x: res[0], y: res[1], z: res[2]};
          m_nxt      = m_r + 1'b1;
        end
        state_nxt = ST_EMITV;
      end
      ST_EMITV: begin
        if (inp_r) begin
          if (vfull) begin
            ovf_nxt = 1'b1;
          end else begin
            vram_we = 1'b1;
            m_after = m_r + 1'b1;
          end
        end
        m_nxt    = m_after;
        prev_nxt = cand_r;
        fs_nxt   = fp_r;
        ins_nxt  = inp_r;
        if (jp1 == n_r) begin
          n_nxt   = m_after;
          cur_nxt = ~cur_r;
          m_nxt   = '0;
          k_nxt   = kp1;
          state_nxt = ((m_after == '0) || (kp1 == wcount_r)) ? ST_OUT : ST_W0;
        end else begin
          j_nxt      = jp1;
          vram_raddr = {cur_r, jp1[pclip_pkg::VI_W-1:0]};
          state_nxt  = ST_VA;
        end
      end
      ST_OUT: begin
        if (n_r == '0) begin
          out_valid_nxt = 1'b1;
          ovtx_nxt      = '0;
          oend_nxt      = 1'b1;
          oemp_nxt      = 1'b1;
          oovf_nxt      = ovf_r;
          state_nxt     = ST_FIN;
        end else begin
          vram_raddr = {cur_r, {pclip_pkg::VI_W{1'b0}}};
          j_nxt      = pclip_pkg::VC_W'(1);
          state_nxt  = ST_OST;
        end
      end
      ST_OST: begin
        out_valid_nxt = 1'b1;
        ovtx_nxt      = vram_rdata;
        oend_nxt      = (j_r == n_r);
        oemp_nxt      = 1'b0;
        oovf_nxt      = ovf_r;
        if (j_r == n_r) begin
          state_nxt = ST_FIN;
        end else begin
          j_nxt = jp1;
        end
      end
      ST_FIN: begin
        scount_nxt = '0;
        wcount_nxt = '0;
        ovf_nxt    = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scount_r    <= '0;
      wcount_r    <= '0;
      ovf_r       <= 1'b0;
      cur_r       <= 1'b0;
      n_r         <= '0;
      m_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      first_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scount_r    <= scount_nxt;
      wcount_r    <= wcount_nxt;
      ovf_r       <= ovf_nxt;
      cur_r       <= cur_nxt;
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wsx_r  <= wsx_nxt;
    wsy_r  <= wsy_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    cand_r <= cand_nxt;
    prev_r <= prev_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    fp_r   <= fp_nxt;
    fs_r   <= fs_nxt;
    ins_r  <= ins_nxt;
    inp_r  <= inp_nxt;
    den_r  <= den_nxt;
    num_r  <= num_nxt;
    dena_r <= dena_nxt;
    neg_r  <= neg_nxt;
    ud_r   <= ud_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    ovtx_r <= ovtx_nxt;
    oend_r <= oend_nxt;
    oemp_r <= oemp_nxt;
    oovf_r <= oovf_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_x            = ovtx_r.x;
  assign out_y            = ovtx_r.y;
  assign out_z            = ovtx_r.z;
  assign out_end_of_run   = oend_r;
  assign out_empty_result = oemp_r;
  assign out_overflowed   = oovf_r;

`ifndef NO_ASSERTIONS
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside a clipping run");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_result) |-> out_end_of_run)
    else $error("empty result word not marked last");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (m_r <= pclip_pkg::VC_W'(pclip_pkg::MAX_VERTS))
      && (n_r <= pclip_pkg::VC_W'(pclip_pkg::MAX_VERTS)))
    else $error("working list count beyond capacity");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dena_r != '0))
    else $error("crossing divide with zero denominator");
`endif

endmodule

>>> rtl/pclip_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pclip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
